FILE: rtl/u8sv_pkg.sv
// Shared types, codes and state helpers of the UTF-8 stream validator.
package u8sv_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned CountW      = 4;
  localparam int unsigned WordBytes   = 8;
  localparam int unsigned MaxLaneIdxW = 4;
  localparam int unsigned NumStates   = 8;
  localparam int unsigned StateIdxW   = 3;

  // Sequence tracker: how many continuation bytes are still owed, with the
  // second-byte range checks after E0, ED, F0 and F4 as states of their own.
  typedef enum logic [NumStates-1:0] {
    ST_START = 8'b0000_0001,
    ST_NEED1 = 8'b0000_0010,
    ST_NEED2 = 8'b0000_0100,
    ST_NEED3 = 8'b0000_1000,
    ST_E0    = 8'b0001_0000,
    ST_ED    = 8'b0010_0000,
    ST_F0    = 8'b0100_0000,
    ST_F4    = 8'b1000_0000
  } seq_state_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BYTE       = 2'd1,
    ERR_UNFINISHED = 2'd2
  } err_kind_e;

  typedef struct packed {
    logic [DataW-1:0]  data_word;
    logic [CountW-1:0] byte_count;
    logic              end_of_message;
  } u8sv_in_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] error_kind;
    logic [2:0] error_position;
  } u8sv_out_t;

  // Outcome of a run of bytes entered from one tracker state.
  typedef struct packed {
    seq_state_e             next;
    logic                   err;
    logic [MaxLaneIdxW-1:0] pos;
  } xfer_t;

  typedef xfer_t [NumStates-1:0] xfer_fn_t;

  function automatic logic [StateIdxW-1:0] state_idx(seq_state_e s);
    logic [StateIdxW-1:0] idx;
    unique case (s)
      ST_START: idx = 3'd0;
      ST_NEED1: idx = 3'd1;
      ST_NEED2: idx = 3'd2;
      ST_NEED3: idx = 3'd3;
      ST_E0:    idx = 3'd4;
      ST_ED:    idx = 3'd5;
      ST_F0:    idx = 3'd6;
      ST_F4:    idx = 3'd7;
      default:  idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic seq_state_e idx_state(logic [StateIdxW-1:0] idx);
    seq_state_e s;
    unique case (idx)
      3'd0:    s = ST_START;
      3'd1:    s = ST_NEED1;
      3'd2:    s = ST_NEED2;
      3'd3:    s = ST_NEED3;
      3'd4:    s = ST_E0;
      3'd5:    s = ST_ED;
      3'd6:    s = ST_F0;
      3'd7:    s = ST_F4;
      default: s = ST_START;
    endcase
    return s;
  endfunction

  function automatic xfer_fn_t ident_fn();
    xfer_fn_t f;
    for (int k = 0; k < NumStates; k++) begin
      f[k].next = idx_state(StateIdxW'(k));
      f[k].err  = 1'b0;
      f[k].pos  = '0;
    end
    return f;
  endfunction

endpackage

FILE: rtl/utf8_stream_validator_core.sv
// Top level of the UTF-8 stream validator: lanes, merge, state and output stages.
// Checks a UTF-8 stream against RFC 3629, up to LANES bytes per item, and returns
// one result per item. Sustained rate is one item per clock while the output is
// not stalled; the merged outcome and then the result are registered. The first stage
// runs every byte lane in parallel and merges them into the item's outcome for each
// possible sequence state; the second stage picks the outcome for the current state,
// so the loop carried from item to item is a single eight-way select. Lanes beyond
// byte 7 see zero bytes, and the error lane is reported modulo eight.
module utf8_stream_validator_core #(
  parameter int unsigned LANES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8sv_pkg::u8sv_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8sv_pkg::u8sv_out_t out_data_o
);
  import u8sv_pkg::*;

  xfer_fn_t [LANES-1:0] lane_fn;
  xfer_fn_t             item_fn;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [7:0] lane_byte;
    logic       lane_active;
    if (i < WordBytes) begin : g_word
      assign lane_byte = in_data_i.data_word[8*i +: 8];
    end else begin : g_zero
      assign lane_byte = 8'h00;
    end
    assign lane_active = (5'(i) < {1'b0, in_data_i.byte_count});

    u8sv_lane u_lane (
      .byte_i     (lane_byte),
      .active_i   (lane_active),
      .lane_idx_i (MaxLaneIdxW'(i)),
      .fn_o       (lane_fn[i])
    );
  end

  u8sv_merge #(
    .LANES (LANES)
  ) u_merge (
    .fn_i (lane_fn),
    .fn_o (item_fn)
  );

  logic       s1_valid_q, s1_valid_d;
  xfer_fn_t   s1_fn_q;
  logic       s1_eom_q;
  seq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  u8sv_out_t  out_q, res_d;
  logic       in_acc, out_free, s1_move;
  xfer_t      sel;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_move    = s1_valid_q && out_free;

  always_comb begin
    sel     = s1_fn_q[state_idx(state_q)];
    state_d = sel.next;
    res_d   = '{ok: 1'b1, error_kind: ERR_NONE, error_position: 3'd0};
    if (sel.err) begin
      res_d.ok             = 1'b0;
      res_d.error_kind     = ERR_BYTE;
      res_d.error_position = sel.pos[2:0];
      state_d              = ST_START;
    end else if (s1_eom_q && (sel.next != ST_START)) begin
      res_d.ok         = 1'b0;
      res_d.error_kind = ERR_UNFINISHED;
      state_d          = ST_START;
    end
  end

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_START;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_fn_q  <= item_fn;
      s1_eom_q <= in_data_i.end_of_message;
    end
    if (s1_move) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_ok_matches_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ok == (out_data_o.error_kind == ERR_NONE)))
    else $error("ok flag disagrees with error kind");

  a_pos_only_on_byte_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.error_kind != ERR_BYTE)) |->
      (out_data_o.error_position == 3'd0))
    else $error("error position set without a byte error");

  a_err_resets_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && (res_d.error_kind != ERR_NONE)) |=> (state_q == ST_START))
    else $error("sequence state not reset after an error");

  a_no_result_from_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q && !out_valid_q) |=> !out_valid_o)
    else $error("result appeared with no item in flight");
`endif

endmodule

FILE: rtl/u8sv_lane.sv
// One byte lane: outcome of its byte for every possible incoming tracker state.
module u8sv_lane (
  input  logic [7:0]                       byte_i,
  input  logic                             active_i,
  input  logic [u8sv_pkg::MaxLaneIdxW-1:0] lane_idx_i,
  output u8sv_pkg::xfer_fn_t               fn_o
);
  import u8sv_pkg::*;

  function automatic xfer_t step_fn(seq_state_e s, logic [7:0] b,
                                    logic [MaxLaneIdxW-1:0] idx);
    xfer_t      r;
    logic       cont;
    logic       good;
    seq_state_e nxt;
    cont = (b[7:6] == 2'b10);
    good = 1'b1;
    nxt  = ST_START;
    unique case (s)
      ST_START: begin
        priority if (b <= 8'h7F) nxt = ST_START;
        else if (b <= 8'hC1) good = 1'b0;
        else if (b <= 8'hDF) nxt = ST_NEED1;
        else if (b == 8'hE0) nxt = ST_E0;
        else if (b == 8'hED) nxt = ST_ED;
        else if (b <= 8'hEF) nxt = ST_NEED2;
        else if (b == 8'hF0) nxt = ST_F0;
        else if (b == 8'hF4) nxt = ST_F4;
        else if (b <= 8'hF4) nxt = ST_NEED3;
        else good = 1'b0;
      end
      ST_NEED1: begin
        good = cont;
        nxt  = ST_START;
      end
      ST_NEED2: begin
        good = cont;
        nxt  = ST_NEED1;
      end
      ST_NEED3: begin
        good = cont;
        nxt  = ST_NEED2;
      end
      ST_E0: begin
        good = cont && (b >= 8'hA0);
        nxt  = ST_NEED1;
      end
      ST_ED: begin
        good = cont && (b <= 8'h9F);
        nxt  = ST_NEED1;
      end
      ST_F0: begin
        good = cont && (b >= 8'h90);
        nxt  = ST_NEED2;
      end
      ST_F4: begin
        good = cont && (b <= 8'h8F);
        nxt  = ST_NEED2;
      end
      default: good = 1'b0;
    endcase
    // Drop back to the start state on an invalid byte
    r.next = good ? nxt : ST_START;
    r.err  = !good;
    r.pos  = idx;
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < NumStates; k++) begin
      if (active_i) begin
        fn_o[k] = step_fn(idx_state(StateIdxW'(k)), byte_i, lane_idx_i);
      end else begin
        fn_o[k].next = idx_state(StateIdxW'(k));
        fn_o[k].err  = 1'b0;
        fn_o[k].pos  = '0;
      end
    end
  end

endmodule

FILE: rtl/u8sv_merge.sv
// Composition tree that folds the lane outcomes into one outcome per item.
module u8sv_merge #(
  parameter int unsigned LANES = 8
) (
  input  u8sv_pkg::xfer_fn_t [LANES-1:0] fn_i,
  output u8sv_pkg::xfer_fn_t             fn_o
);
  import u8sv_pkg::*;

  localparam int unsigned IdxW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned NP   = 1 << IdxW;

  // Earlier lanes first; an error stops the later lanes from counting.
  function automatic xfer_fn_t compose_fn(xfer_fn_t a, xfer_fn_t b);
    xfer_fn_t r;
    for (int k = 0; k < NumStates; k++) begin
      if (a[k].err) begin
        r[k] = a[k];
      end else begin
        r[k] = b[state_idx(a[k].next)];
      end
    end
    return r;
  endfunction

  xfer_fn_t node [2*NP-1];

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < LANES) begin : g_used
      assign node[NP-1+j] = fn_i[j];
    end else begin : g_pad
      assign node[NP-1+j] = ident_fn();
    end
  end

  for (genvar k = 0; k < NP - 1; k++) begin : g_node
    assign node[k] = compose_fn(node[2*k+1], node[2*k+2]);
  end

  assign fn_o = node[0];

endmodule

FILE: tb/u8sv_verdict_checker.sv
// Channel monitor, UTF-8 verdict predictor and result scoreboard for the stream validator.
`timescale 1ns / 100ps

module u8sv_verdict_checker
  import u8sv_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  u8sv_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  u8sv_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        clean_count_o,
  output int        byte_err_count_o,
  output int        unfinished_count_o
);

  localparam logic [7:0] NO_LEAD = 8'hFF;
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;
  localparam int         REPORT_MAX = 10;

  // Sequence tracker: position of the next byte (1 = lead), open lead byte, length.
  logic [2:0] seq_pos;
  logic [7:0] seq_lead;
  logic [2:0] seq_len;

  u8sv_out_t verdict_q[$];

  function automatic void to_start();
    seq_pos  = 3'd1;
    seq_lead = NO_LEAD;
    seq_len  = 3'd1;
  endfunction

  // Check one byte against the open sequence and advance; return 0 on an invalid byte.
  function automatic logic step_byte(logic [7:0] b);
    logic good;
    logic done;
    logic is_cont;
    good    = 1'b1;
    done    = 1'b0;
    is_cont = (b[7:6] == 2'b10);
    case (seq_pos)
      3'd1: begin
        seq_lead = b;
        if (b <= 8'h7F) done = 1'b1;
        else if (b <= 8'hC1) good = 1'b0;
        else if (b <= 8'hDF) seq_len = 3'd2;
        else if (b <= 8'hEF) seq_len = 3'd3;
        else if (b <= 8'hF4) seq_len = 3'd4;
        else good = 1'b0;
      end
      3'd2: begin
        if (!is_cont) good = 1'b0;
        // overlong forms, surrogates and values past the top of the code space
        if (seq_lead == LEAD_E0 && b < 8'hA0) good = 1'b0;
        if (seq_lead == LEAD_ED && b > 8'h9F) good = 1'b0;
        if (seq_lead == LEAD_F0 && b < 8'h90) good = 1'b0;
        if (seq_lead == LEAD_F4 && b > 8'h8F) good = 1'b0;
        if (seq_len == 3'd2) done = 1'b1;
      end
      3'd3: begin
        if (!is_cont) good = 1'b0;
        if (seq_len == 3'd3) done = 1'b1;
      end
      3'd4: begin
        if (!is_cont) good = 1'b0;
        done = 1'b1;
      end
      default: good = 1'b0;
    endcase
    if (done || !good) to_start();
    else seq_pos = seq_pos + 3'd1;
    return good;
  endfunction

  function automatic u8sv_out_t validate_item(u8sv_in_t it);
    int unsigned lanes_used;
    logic [7:0]  b;
    err_kind_e   kind;
    logic [2:0]  lane;
    u8sv_out_t   r;
    lanes_used = (it.byte_count > LANES) ? LANES : it.byte_count;
    kind       = ERR_NONE;
    lane       = '0;
    // stop at the first bad byte: the rest of the item is dropped
    for (int i = 0; i < lanes_used && kind == ERR_NONE; i++) begin
      b = (i < WordBytes) ? it.data_word[8*i +: 8] : 8'h00;
      if (!step_byte(b)) begin
        kind = ERR_BYTE;
        lane = 3'(i);
      end
    end
    if (kind == ERR_NONE && it.end_of_message && seq_lead != NO_LEAD) begin
      kind = ERR_UNFINISHED;
      to_start();
    end
    r.ok             = (kind == ERR_NONE);
    r.error_kind     = kind;
    r.error_position = lane;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    u8sv_out_t want;
    if (!rst_ni) begin
      to_start();
      verdict_q.delete();
      fail_count_o       = 0;
      pending_o          = 0;
      clean_count_o      = 0;
      byte_err_count_o   = 0;
      unfinished_count_o = 0;
    end else begin
      // compare before taking the new item in: a result can never overtake its item
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: result with no item outstanding: ok=%0b kind=%0d lane=%0d",
                     $realtime, out_data_i.ok, out_data_i.error_kind,
                     out_data_i.error_position);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (want.error_kind == ERR_NONE) clean_count_o++;
          else if (want.error_kind == ERR_BYTE) byte_err_count_o++;
          else unfinished_count_o++;
          if (out_data_i.ok !== want.ok || out_data_i.error_kind !== want.error_kind ||
              out_data_i.error_position !== want.error_position) begin
            if (fail_count_o < REPORT_MAX)
              $display("%0t: expected ok=%0b kind=%0d lane=%0d, got ok=%0b kind=%0d lane=%0d",
                       $realtime, want.ok, want.error_kind, want.error_position,
                       out_data_i.ok, out_data_i.error_kind, out_data_i.error_position);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) verdict_q.push_back(validate_item(in_data_i));
      pending_o = verdict_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the stream validator testbench: clock, reset, byte-stream stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import u8sv_pkg::*;

  localparam int unsigned LANES        = 8;
  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned N_RANDOM     = 1100;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  u8sv_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  u8sv_out_t out_data;

  int fail_count;
  int pending;
  int clean_count;
  int byte_err_count;
  int unfinished_count;

  int unsigned sent         = 0;
  int unsigned directed     = 0;
  int unsigned burst_left   = 0;
  int unsigned stalled      = 0;
  int unsigned cycles       = 0;
  logic        hold_req     = 1'b0;
  logic        hold_taken   = 1'b0;

  logic [7:0] stream_q[$];

  always #(HALF_PERIOD) clk_i = ~clk_i;

  utf8_stream_validator_core #(
    .LANES(LANES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  u8sv_verdict_checker #(
    .LANES(LANES)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .clean_count_o     (clean_count),
    .byte_err_count_o  (byte_err_count),
    .unfinished_count_o(unfinished_count)
  );

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_ready) stalled++;
  end

  // Append one character to the byte stream, now and then with a flaw in it.
  function automatic void push_char();
    logic [7:0]  seq [4];
    int unsigned len;
    int unsigned flaw;
    int unsigned keep;
    int unsigned r;
    r = $urandom_range(0, 9);
    len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : 4;
    for (int k = 1; k < 4; k++) seq[k] = 8'($urandom_range(8'h80, 8'hBF));
    case (len)
      1: seq[0] = 8'($urandom_range(8'h00, 8'h7F));
      2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
      3: begin
        r = $urandom_range(0, 3);
        seq[0] = (r == 0) ? 8'hE0 : (r == 1) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
      end
      default: begin
        r = $urandom_range(0, 3);
        seq[0] = (r == 0) ? 8'hF0 : (r == 1) ? 8'hF4 : 8'($urandom_range(8'hF0, 8'hF4));
      end
    endcase
    case (seq[0])
      8'hE0:   seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
      8'hED:   seq[1] = 8'($urandom_range(8'h80, 8'h9F));
      8'hF0:   seq[1] = 8'($urandom_range(8'h90, 8'hBF));
      8'hF4:   seq[1] = 8'($urandom_range(8'h80, 8'h8F));
      default: ;
    endcase
    keep = len;
    flaw = $urandom_range(0, 99);
    if (flaw < 2) begin
      seq[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                    : 8'($urandom_range(8'hF5, 8'hFF));
    end else if (flaw < 4 && len > 1) begin
      keep = $urandom_range(1, len - 1);
    end else if (flaw < 6 && len > 1) begin
      // push the second byte just outside the range its lead allows
      case (seq[0])
        8'hE0:   seq[1] = 8'($urandom_range(8'h80, 8'h9F));
        8'hED:   seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
        8'hF0:   seq[1] = 8'($urandom_range(8'h80, 8'h8F));
        8'hF4:   seq[1] = 8'($urandom_range(8'h90, 8'hBF));
        default: seq[1] = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                               : 8'($urandom_range(8'hC0, 8'hFF));
      endcase
    end else if (flaw < 8 && len > 1) begin
      seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < keep; k++) stream_q.push_back(seq[k]);
    // runs of plain ASCII, so whole words of it turn up
    if (len == 1) repeat ($urandom_range(0, 6)) stream_q.push_back(8'($urandom_range(0, 8'h7F)));
  endfunction

  function automatic u8sv_in_t next_item();
    u8sv_in_t    it;
    int unsigned r;
    int unsigned n;
    int unsigned take;
    r = $urandom_range(0, 99);
    it.data_word      = {$urandom, $urandom};
    it.end_of_message = ($urandom_range(0, 9) == 0);
    if (r < 6) begin
      // noise: raw word, any count
      it.byte_count = CountW'($urandom_range(0, 15));
    end else begin
      n = (r < 9) ? 0 : (r < 14) ? $urandom_range(9, 15) : (r < 45) ? 8 : $urandom_range(1, 8);
      take = (n > WordBytes) ? WordBytes : n;
      while (stream_q.size() < take) push_char();
      for (int i = 0; i < take; i++) it.data_word[8*i +: 8] = stream_q.pop_front();
      it.byte_count = CountW'(n);
    end
    return it;
  endfunction

  // Offer one item in bursts with random gaps; hold it until taken.
  task automatic send(input u8sv_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    if (sent == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic send_fields(input logic [63:0] word, input int unsigned count, input logic eom);
    u8sv_in_t it;
    it.data_word      = word;
    it.byte_count     = CountW'(count);
    it.end_of_message = eom;
    send(it);
    directed++;
  endtask

  // Receiver: ready pattern changes phase by phase, with one long hold-off.
  initial begin : receiver
    int unsigned phase_left;
    int unsigned mode;
    int unsigned hold_left;
    phase_left = 0;
    mode       = 0;
    hold_left  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= phase_left[2];
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(64'h7F7F_7F7F_7F7F_7F7F, 8, 1'b1);
    send_fields(64'h0000_0000_BFDF_80C2, 4, 1'b1);
    send_fields(64'h0000_BF9F_ED80_A0E0, 6, 1'b0);
    send_fields(64'hBFBF_8FF4_8080_90F0, 8, 1'b1);
    send_fields(64'h0000_0000_0000_00C0, 1, 1'b0);  // overlong two-byte lead
    send_fields(64'h0000_0000_0000_C141, 2, 1'b0);
    send_fields(64'h0000_0000_00F5_4241, 3, 1'b0);  // lead above F4
    send_fields(64'h0000_0000_0000_00FF, 1, 1'b1);  // bad byte and end of message together
    send_fields(64'h0000_0000_0000_0080, 1, 1'b0);  // stray continuation
    send_fields(64'h0000_0000_0000_9FE0, 2, 1'b0);  // overlong three-byte form
    send_fields(64'h0000_0000_0000_A0ED, 2, 1'b0);  // surrogate
    send_fields(64'h0000_0000_0000_8FF0, 2, 1'b0);  // overlong four-byte form
    send_fields(64'h0000_0000_0000_90F4, 2, 1'b0);  // beyond the top code point
    send_fields(64'h0000_0000_0000_41C2, 2, 1'b0);
    send_fields(64'h0000_0000_0000_80E1, 2, 1'b0);  // sequence split across items
    send_fields(64'h0000_0000_0000_0080, 1, 1'b1);
    send_fields(64'h0000_0000_0080_80F1, 3, 1'b1);  // cut short at end of message
    send_fields(64'h0000_0000_0000_00E2, 1, 1'b0);
    send_fields(64'h0000_0000_0000_0000, 0, 1'b1);  // empty item closes an open sequence
    send_fields(64'h0000_0000_0000_0000, 0, 1'b0);
    send_fields(64'h8041_4141_4141_4141, 15, 1'b0); // count saturates, error in top lane
    send_fields(64'h4141_4141_4141_4141, 9, 1'b1);
    send_fields(64'hFFFF_FFFF_FFFF_FF41, 1, 1'b0);  // unused lanes ignored
    send_fields(64'h0000_0000_0000_BFF3, 2, 1'b0);
    send_fields(64'h0000_0000_0000_BFBF, 2, 1'b1);

    for (int k = 0; k < N_RANDOM; k++) send(next_item());
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d items (%0d directed); results %0d clean, %0d bad byte, %0d cut short",
             sent, directed, clean_count, byte_err_count, unfinished_count);
    $display("Input back-pressured for %0d cycles, one receiver hold-off of %0d cycles",
             stalled, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/u8sv_pkg.sv
rtl/u8sv_lane.sv
rtl/u8sv_merge.sv
rtl/utf8_stream_validator_core.sv
tb/u8sv_verdict_checker.sv
tb/testbench.sv
